// ----- src/bap_pkg.sv -----
// ----------------------------------------------------------------------------
// bap_pkg: shared types and constants for the BGRA alpha presentation block
// Register indexes, usage and encoding codes, pipeline payload types.
// ----------------------------------------------------------------------------
package bap_pkg;

    localparam int unsigned NUM_LANES = 3;   // blue, green, red
    localparam int unsigned NUM_CELLS = 8;   // one quotient bit per cell

    localparam logic [1:0] USAGE_AUTO   = 2'd0;
    localparam logic [1:0] USAGE_DATA   = 2'd1;

    localparam logic [1:0] ENC_UNKNOWN  = 2'd0;
    localparam logic [1:0] ENC_OPAQUE   = 2'd1;
    localparam logic [1:0] ENC_STRAIGHT = 2'd2;
    localparam logic [1:0] ENC_PREMULT  = 2'd3;

    localparam logic [7:0]  ALPHA_FULL  = 8'd255;
    localparam logic [15:0] PREM_ROUND  = 16'd127;

    typedef enum logic [1:0] {
        REG_OVERRIDE = 2'd0,
        REG_HINT     = 2'd1,
        REG_ENCODING = 2'd2,
        REG_BLOCK    = 2'd3
    } t_reg_idx;

    // Per-pixel operation resolved at the pipeline entry
    typedef enum logic [1:0] {
        OP_PASS   = 2'd0,   // color and alpha unchanged
        OP_OPAQUE = 2'd1,   // color unchanged, alpha forced full
        OP_UNPREM = 2'd2,   // unpremultiply, alpha forced full
        OP_PREM   = 2'd3    // premultiply, alpha kept
    } t_op;

    typedef struct packed {
        logic [7:0]  rem;   // partial remainder of the division
        logic [7:0]  quo;   // low numerator bits, shifted out as quotient comes in
        logic        sat;   // quotient exceeds 255
        logic [7:0]  col;   // original color byte
        logic [15:0] prod;  // color times alpha
    } t_lane;

    typedef struct packed {
        t_op                  op;
        logic [7:0]           alpha;
        t_lane [NUM_LANES-1:0] lane;
    } t_item;

endpackage

// ----- src/bgra_alpha_presentation.sv -----
// ----------------------------------------------------------------------------
// bgra_alpha_presentation: prepares 8-bit BGRA pixels for display
// Resolves alpha usage from the registers. Data usage forces full alpha and
// unpremultiplies premultiplied pixels; coverage premultiplies all others.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel input channel (i_in_valid / o_in_ready) takes one BGRA pixel per
//   transfer; the result channel (o_out_valid / i_out_ready) returns one
//   presented pixel per input pixel, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes one register
//   per transfer; it is always ready. Write it only while no pixel is in
//   flight.
//   Pipeline: one entry stage, eight division cells (one quotient bit each)
//   and the output register.
//   Throughput: one pixel per cycle while the receiver is ready. Every stage
//   has its own valid bit and takes a new item whenever it is empty or its
//   successor advances, so a stalled receiver first fills the bubbles in the
//   cell chain and only then backs up the input.
//   Reset: all stage valid bits clear and the four registers return to
//   zero (auto usage, unknown encoding, not block compressed).
// ----------------------------------------------------------------------------
module bgra_alpha_presentation import bap_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [1:0] i_cfg_data,
    // pixel input
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_blue_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_alpha_in,
    // presented pixel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_blue_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_red_out,
    output logic [7:0] o_alpha_out
);

    // Configuration registers
    logic [1:0] r_usage_override;
    logic [1:0] r_usage_hint;
    logic [1:0] r_alpha_encoding;
    logic       r_block_compressed;

    logic       w_data_mode;
    logic       w_premult;
    t_op        w_op;

    logic                      w_valid [0:NUM_CELLS];
    logic                      w_ready [0:NUM_CELLS];
    t_item                     w_item  [0:NUM_CELLS];
    logic [NUM_LANES-1:0][7:0] w_col;
    logic [NUM_LANES-1:0][7:0] w_out_col;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usage_override   <= USAGE_AUTO;
            r_usage_hint       <= USAGE_AUTO;
            r_alpha_encoding   <= ENC_UNKNOWN;
            r_block_compressed <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_OVERRIDE: r_usage_override   <= i_cfg_data;
                REG_HINT:     r_usage_hint       <= i_cfg_data;
                REG_ENCODING: r_alpha_encoding   <= i_cfg_data;
                REG_BLOCK:    r_block_compressed <= i_cfg_data[0];
                default:      r_block_compressed <= r_block_compressed;
            endcase
        end
    end

    // Usage priority: override, hint, opaque encoding, block-compressed
    // straight or unknown source, otherwise coverage. Any nonzero code
    // other than data behaves as coverage.
    always_comb begin
        if (r_usage_override != USAGE_AUTO) begin
            w_data_mode = (r_usage_override == USAGE_DATA);
        end else if (r_usage_hint != USAGE_AUTO) begin
            w_data_mode = (r_usage_hint == USAGE_DATA);
        end else if (r_alpha_encoding == ENC_OPAQUE) begin
            w_data_mode = 1'b1;
        end else begin
            w_data_mode = r_block_compressed &&
                (r_alpha_encoding == ENC_STRAIGHT || r_alpha_encoding == ENC_UNKNOWN);
        end
    end

    assign w_premult = (r_alpha_encoding == ENC_PREMULT);

    // Pick the per-pixel operation; zero alpha never takes the unpremultiply path
    always_comb begin
        if (w_data_mode) begin
            w_op = (w_premult && i_alpha_in != 8'd0) ? OP_UNPREM : OP_OPAQUE;
        end else begin
            w_op = w_premult ? OP_PASS : OP_PREM;
        end
    end

    assign w_col[0] = i_blue_in;
    assign w_col[1] = i_green_in;
    assign w_col[2] = i_red_in;

    bap_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_op    (w_op),
        .i_col   (w_col),
        .i_alpha (i_alpha_in),
        .o_valid (w_valid[0]),
        .o_item  (w_item[0]),
        .i_ready (w_ready[0])
    );

    // Division chain: each cell adds one quotient bit, MSB first
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        bap_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_item  (w_item[g]),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    bap_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NUM_CELLS]),
        .o_ready (w_ready[NUM_CELLS]),
        .i_item  (w_item[NUM_CELLS]),
        .o_valid (o_out_valid),
        .o_col   (w_out_col),
        .o_alpha (o_alpha_out),
        .i_ready (i_out_ready)
    );

    assign o_blue_out  = w_out_col[0];
    assign o_green_out = w_out_col[1];
    assign o_red_out   = w_out_col[2];

    // Data usage always presents full alpha
    a_data_alpha_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && w_data_mode |-> o_alpha_out == ALPHA_FULL)
        else $error("data usage result without full alpha");

    // A premultiplied color never exceeds its alpha
    a_prem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !w_data_mode && !w_premult |->
            o_blue_out <= o_alpha_out && o_green_out <= o_alpha_out &&
            o_red_out <= o_alpha_out)
        else $error("premultiplied color above alpha");

    // An accepted pixel lands in the entry stage
    a_entry_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> w_valid[0])
        else $error("accepted pixel lost at entry stage");

endmodule

// ----- src/bap_front.sv -----
// ----------------------------------------------------------------------------
// bap_front: entry stage
// Forms the division numerators, the saturation flags and the premultiply
// products, and registers them with the resolved operation.
// ----------------------------------------------------------------------------
module bap_front import bap_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  t_op                         i_op,
    input  logic [NUM_LANES-1:0][7:0]   i_col,
    input  logic [7:0]                  i_alpha,
    output logic                        o_valid,
    output t_item                       o_item,
    input  logic                        i_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        logic [15:0] num;
        n_item.op    = i_op;
        n_item.alpha = i_alpha;
        for (int k = 0; k < NUM_LANES; k++) begin
            // c*255 + a/2
            num = {i_col[k], 8'd0} - {8'd0, i_col[k]} + {9'd0, i_alpha[7:1]};
            n_item.lane[k].rem  = num[15:8];
            n_item.lane[k].quo  = num[7:0];
            n_item.lane[k].sat  = (num[15:8] >= i_alpha);
            n_item.lane[k].col  = i_col[k];
            n_item.lane[k].prod = {8'd0, i_col[k]} * {8'd0, i_alpha};
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- src/bap_div_cell.sv -----
// ----------------------------------------------------------------------------
// bap_div_cell: one restoring-division cell
// Resolves one quotient bit per lane and hands the item to the next cell.
// ----------------------------------------------------------------------------
module bap_div_cell import bap_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        logic [8:0] trial;
        logic [8:0] diff;
        logic       ge;
        n_item = i_item;
        for (int k = 0; k < NUM_LANES; k++) begin
            trial = {i_item.lane[k].rem, i_item.lane[k].quo[7]};
            diff  = trial - {1'b0, i_item.alpha};
            ge    = (trial >= {1'b0, i_item.alpha});
            n_item.lane[k].rem = ge ? diff[7:0] : trial[7:0];
            n_item.lane[k].quo = {i_item.lane[k].quo[6:0], ge};
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- src/bap_finish.sv -----
// ----------------------------------------------------------------------------
// bap_finish: output stage
// Completes the premultiply divide by 255, applies saturation and selects
// the presented pixel into the output register.
// ----------------------------------------------------------------------------
module bap_finish import bap_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  t_item                       i_item,
    output logic                        o_valid,
    output logic [NUM_LANES-1:0][7:0]   o_col,
    output logic [7:0]                  o_alpha,
    input  logic                        i_ready
);

    logic                       r_valid;
    logic [NUM_LANES-1:0][7:0]  r_col;
    logic [7:0]                 r_alpha;
    logic [NUM_LANES-1:0][7:0]  n_col;
    logic [7:0]                 n_alpha;

    always_comb begin
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  unp;
        n_alpha = i_item.alpha;
        for (int k = 0; k < NUM_LANES; k++) begin
            // x / 255 for x below 65280
            x   = i_item.lane[k].prod + PREM_ROUND;
            y   = x + {8'd0, x[15:8]} + 16'd1;
            unp = i_item.lane[k].sat ? ALPHA_FULL : i_item.lane[k].quo;
            case (i_item.op)
                OP_PASS:   n_col[k] = i_item.lane[k].col;
                OP_OPAQUE: n_col[k] = i_item.lane[k].col;
                OP_UNPREM: n_col[k] = unp;
                OP_PREM:   n_col[k] = y[15:8];
                default:   n_col[k] = i_item.lane[k].col;
            endcase
        end
        if (i_item.op == OP_OPAQUE || i_item.op == OP_UNPREM) begin
            n_alpha = ALPHA_FULL;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_col   = r_col;
    assign o_alpha = r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_col   <= n_col;
            r_alpha <= n_alpha;
        end
    end

endmodule

// ----- test/bgra_alpha_presentation_tb.sv -----
// ----------------------------------------------------------------------------
// bgra_alpha_presentation_tb: self-checking bench for the alpha presentation
// Drives BGRA pixels under many register settings and compares every
// presented pixel with a hand-written result or an in-bench model of the
// usage resolution and the premultiply / unpremultiply arithmetic.
// ----------------------------------------------------------------------------
module bgra_alpha_presentation_tb;
    import bap_pkg::*;

    // Usage codes the package does not name
    localparam logic [1:0] USAGE_COVER = 2'd2;
    localparam logic [1:0] USAGE_ODD   = 2'd3;   // nonzero but neither data nor coverage

    localparam int unsigned IDLE_PCT      = 18;
    localparam int unsigned RANDOM_ITEMS  = 950;
    localparam int unsigned MAX_SHOWN     = 10;
    localparam int unsigned DRAIN_CYCLES  = 16;   // pipeline is 10 deep
    localparam int unsigned HOLD_CYCLES   = 80;   // long receiver back-off
    localparam int unsigned TIMEOUT_UNITS = 2_000_000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } t_bgra;

    // Shadow of the four configuration registers
    typedef struct packed {
        logic [1:0] override_u;
        logic [1:0] hint_u;
        logic [1:0] encoding;
        logic       block;
    } t_setup;

    // One directed row: settings, pixel, and a hand-written result if obvious
    typedef struct packed {
        t_setup setup;
        t_bgra  pix;
        logic   typed;
        t_bgra  want;
    } t_row;

    localparam t_bgra NONE = '0;

    localparam t_setup S_AUTO      = '{USAGE_AUTO, USAGE_AUTO, ENC_UNKNOWN, 1'b0};
    localparam t_setup S_OPAQUE    = '{USAGE_AUTO, USAGE_AUTO, ENC_OPAQUE, 1'b0};
    localparam t_setup S_PREM      = '{USAGE_AUTO, USAGE_AUTO, ENC_PREMULT, 1'b0};
    localparam t_setup S_PREM_DATA = '{USAGE_DATA, USAGE_AUTO, ENC_PREMULT, 1'b0};
    localparam t_setup S_BC_STR    = '{USAGE_AUTO, USAGE_AUTO, ENC_STRAIGHT, 1'b1};
    localparam t_setup S_BC_UNK    = '{USAGE_AUTO, USAGE_AUTO, ENC_UNKNOWN, 1'b1};
    localparam t_setup S_BC_PREM   = '{USAGE_AUTO, USAGE_AUTO, ENC_PREMULT, 1'b1};
    localparam t_setup S_STRAIGHT  = '{USAGE_AUTO, USAGE_AUTO, ENC_STRAIGHT, 1'b0};
    localparam t_setup S_HINT_DATA = '{USAGE_AUTO, USAGE_DATA, ENC_STRAIGHT, 1'b0};
    localparam t_setup S_HINT_COV  = '{USAGE_AUTO, USAGE_COVER, ENC_OPAQUE, 1'b1};
    localparam t_setup S_HINT_ODD  = '{USAGE_AUTO, USAGE_ODD, ENC_PREMULT, 1'b0};
    localparam t_setup S_OVR_ODD   = '{USAGE_ODD, USAGE_DATA, ENC_STRAIGHT, 1'b0};
    localparam t_setup S_OVR_COV   = '{USAGE_COVER, USAGE_DATA, ENC_OPAQUE, 1'b0};
    localparam t_setup S_OVR_DATA  = '{USAGE_DATA, USAGE_COVER, ENC_PREMULT, 1'b1};
    localparam t_setup S_ALL_MAX   = '{USAGE_ODD, USAGE_ODD, ENC_PREMULT, 1'b1};

    localparam int unsigned NUM_ROWS = 23;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        // reset settings: coverage usage, unknown encoding, so premultiply
        '{S_AUTO, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{S_AUTO, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{S_AUTO, '{8'd255, 8'd128, 8'd1, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{S_AUTO, '{8'd200, 8'd100, 8'd50, 8'd128}, 1'b0, NONE},
        // opaque encoding resolves to data: color kept, alpha full
        '{S_OPAQUE, '{8'd12, 8'd34, 8'd56, 8'd78}, 1'b1, '{8'd12, 8'd34, 8'd56, 8'd255}},
        // premultiplied pixel in coverage usage passes through
        '{S_PREM, '{8'd90, 8'd80, 8'd70, 8'd60}, 1'b1, '{8'd90, 8'd80, 8'd70, 8'd60}},
        // unpremultiply: saturation, zero alpha, extremes
        '{S_PREM_DATA, '{8'd255, 8'd255, 8'd255, 8'd1}, 1'b1,
          '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{S_PREM_DATA, '{8'd10, 8'd20, 8'd30, 8'd0}, 1'b1, '{8'd10, 8'd20, 8'd30, 8'd255}},
        '{S_PREM_DATA, '{8'd100, 8'd50, 8'd0, 8'd200}, 1'b0, NONE},
        '{S_PREM_DATA, '{8'd0, 8'd0, 8'd0, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd255}},
        '{S_PREM_DATA, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{S_PREM_DATA, '{8'd1, 8'd1, 8'd1, 8'd2}, 1'b0, NONE},
        '{S_PREM_DATA, '{8'd128, 8'd255, 8'd0, 8'd128}, 1'b0, NONE},
        // block-compressed straight or unknown resolves to data
        '{S_BC_STR, '{8'd1, 8'd2, 8'd3, 8'd4}, 1'b1, '{8'd1, 8'd2, 8'd3, 8'd255}},
        '{S_BC_UNK, '{8'd200, 8'd0, 8'd255, 8'd0}, 1'b1, '{8'd200, 8'd0, 8'd255, 8'd255}},
        '{S_BC_PREM, '{8'd5, 8'd6, 8'd7, 8'd8}, 1'b1, '{8'd5, 8'd6, 8'd7, 8'd8}},
        '{S_STRAIGHT, '{8'd128, 8'd64, 8'd32, 8'd192}, 1'b0, NONE},
        // hint and override precedence, usage code three acts as coverage
        '{S_HINT_DATA, '{8'd9, 8'd9, 8'd9, 8'd9}, 1'b1, '{8'd9, 8'd9, 8'd9, 8'd255}},
        '{S_HINT_COV, '{8'd255, 8'd0, 8'd128, 8'd100}, 1'b0, NONE},
        '{S_HINT_ODD, '{8'd44, 8'd55, 8'd66, 8'd77}, 1'b1, '{8'd44, 8'd55, 8'd66, 8'd77}},
        '{S_OVR_ODD, '{8'd255, 8'd255, 8'd255, 8'd128}, 1'b0, NONE},
        '{S_OVR_COV, '{8'd77, 8'd88, 8'd99, 8'd111}, 1'b0, NONE},
        '{S_OVR_DATA, '{8'd127, 8'd128, 8'd254, 8'd255}, 1'b0, NONE}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [1:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_blue_in;
    logic [7:0] i_green_in;
    logic [7:0] i_red_in;
    logic [7:0] i_alpha_in;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_blue_out;
    logic [7:0] o_green_out;
    logic [7:0] o_red_out;
    logic [7:0] o_alpha_out;

    t_setup      live_setup = S_AUTO;   // registers as the block holds them
    t_bgra       due_pixels[$];         // presented pixels still to come, oldest first
    int unsigned fail_count = 0;
    int unsigned hold_left  = 0;        // cycles the receiver still holds off
    bit          gaps_on    = 1'b1;     // random idling on both sides

    bgra_alpha_presentation DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .i_alpha_in  (i_alpha_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out),
        .o_alpha_out (o_alpha_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin : watchdog
        #(TIMEOUT_UNITS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------

    // round(c * 255 / a), clamped to a byte; a is nonzero
    function automatic logic [7:0] unprem_byte(input logic [7:0] c, input logic [7:0] a);
        int unsigned q;
        q = (32'(c) * 32'(ALPHA_FULL) + 32'(a) / 2) / 32'(a);
        return (q > 32'(ALPHA_FULL)) ? ALPHA_FULL : q[7:0];
    endfunction

    // round(c * a / 255)
    function automatic logic [7:0] prem_byte(input logic [7:0] c, input logic [7:0] a);
        int unsigned q;
        q = (32'(c) * 32'(a) + 32'(PREM_ROUND)) / 32'(ALPHA_FULL);
        return q[7:0];
    endfunction

    function automatic t_bgra present_pixel(input t_bgra px, input t_setup s);
        logic [1:0] usage;
        logic       is_prem;
        t_bgra      q;
        // Priority: override, hint, opaque, block-compressed straight/unknown
        if (s.override_u != USAGE_AUTO)
            usage = s.override_u;
        else if (s.hint_u != USAGE_AUTO)
            usage = s.hint_u;
        else if (s.encoding == ENC_OPAQUE)
            usage = USAGE_DATA;
        else if (s.block && (s.encoding == ENC_STRAIGHT || s.encoding == ENC_UNKNOWN))
            usage = USAGE_DATA;
        else
            usage = USAGE_COVER;
        is_prem = (s.encoding == ENC_PREMULT);
        q = px;
        if (usage == USAGE_DATA) begin
            if (is_prem && px.alpha != 8'd0) begin
                q.blue  = unprem_byte(px.blue, px.alpha);
                q.green = unprem_byte(px.green, px.alpha);
                q.red   = unprem_byte(px.red, px.alpha);
            end
            q.alpha = ALPHA_FULL;
        end else if (!is_prem) begin
            q.blue  = prem_byte(px.blue, px.alpha);
            q.green = prem_byte(px.green, px.alpha);
            q.red   = prem_byte(px.red, px.alpha);
        end
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly uniform, now and then a corner value
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one pixel and hold it until the transfer; queue what must come back
    task automatic send_pixel(input t_bgra px, input logic typed, input t_bgra want);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_blue_in  <= px.blue;
        i_green_in <= px.green;
        i_red_in   <= px.red;
        i_alpha_in <= px.alpha;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        due_pixels.push_back(typed ? want : present_pixel(px, live_setup));
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Drain the pipeline, then rewrite all four registers
    task automatic apply_setup(input t_setup s);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (due_pixels.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
        write_reg(REG_OVERRIDE, s.override_u);
        write_reg(REG_HINT, s.hint_u);
        write_reg(REG_ENCODING, s.encoding);
        write_reg(REG_BLOCK, {1'b0, s.block});
        live_setup = s;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: directed table, then random phases under changing settings
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_bgra       px;
        t_setup      s;
        int unsigned sent;
        int unsigned phase;
        int unsigned phase_len;

        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_OVERRIDE;
        i_cfg_data  = 2'd0;
        i_in_valid  = 1'b0;
        i_blue_in   = 8'd0;
        i_green_in  = 8'd0;
        i_red_in    = 8'd0;
        i_alpha_in  = 8'd0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First rows run on the reset values, so no write until settings change
        for (int k = 0; k < NUM_ROWS; k++) begin
            if (DIRECTED[k].setup != live_setup)
                apply_setup(DIRECTED[k].setup);
            send_pixel(DIRECTED[k].pix, DIRECTED[k].typed, DIRECTED[k].want);
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase == 0) begin
                s = S_AUTO;
            end else if (phase == 1) begin
                s = S_ALL_MAX;
            end else if (phase % 3 == 2) begin
                // forced data on premultiplied input: the unpremultiply path
                s.override_u = USAGE_DATA;
                s.hint_u     = 2'($urandom_range(0, 3));
                s.encoding   = ENC_PREMULT;
                s.block      = 1'($urandom_range(0, 1));
            end else begin
                s.override_u = $urandom_range(0, 1) ? USAGE_AUTO : 2'($urandom_range(1, 3));
                s.hint_u     = $urandom_range(0, 1) ? USAGE_AUTO : 2'($urandom_range(1, 3));
                s.encoding   = 2'($urandom_range(0, 3));
                s.block      = 1'($urandom_range(0, 1));
            end
            apply_setup(s);

            // one phase runs flat out on both sides
            gaps_on = (phase != 3);
            // hold off the receiver long enough to back up the input
            if (phase == 2)
                hold_left = HOLD_CYCLES;

            phase_len = $urandom_range(40, 110);
            repeat (phase_len) begin
                px.alpha = pick_byte();
                // premultiplied input is mostly well formed: color <= alpha
                if (live_setup.encoding == ENC_PREMULT && $urandom_range(0, 4) != 0) begin
                    px.blue  = 8'($urandom_range(0, px.alpha));
                    px.green = 8'($urandom_range(0, px.alpha));
                    px.red   = 8'($urandom_range(0, px.alpha));
                end else begin
                    px.blue  = pick_byte();
                    px.green = pick_byte();
                    px.red   = pick_byte();
                end
                send_pixel(px, 1'b0, NONE);
            end
            sent += phase_len;
            phase++;
        end

        gaps_on = 1'b1;
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (due_pixels.size() != 0) @(negedge i_clk);
        // catch anything spurious the pipeline might still push out
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each transfer, then pick next cycle's ready
    // ------------------------------------------------------------------------
    initial begin : result_side
        t_bgra got;
        t_bgra want;

        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got = '{o_blue_out, o_green_out, o_red_out, o_alpha_out};
                if (due_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("unexpected result: b=%0d g=%0d r=%0d a=%0d",
                                 got.blue, got.green, got.red, got.alpha);
                end else begin
                    want = due_pixels.pop_front();
                    if (got.blue !== want.blue || got.green !== want.green ||
                        got.red !== want.red || got.alpha !== want.alpha) begin
                        fail_count++;
                        if (fail_count <= MAX_SHOWN)
                            $display("mismatch: exp b=%0d g=%0d r=%0d a=%0d, got b=%0d g=%0d r=%0d a=%0d",
                                     want.blue, want.green, want.red, want.alpha,
                                     got.blue, got.green, got.red, got.alpha);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

endmodule
